>>> src/ssh_pkg.sv
// Shared types and constants for the sorted sparse histogram.
// Holds the field widths, operation and status codes, and the sequencer states.
// No dependencies.
package ssh_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS     = 16;
  localparam int COUNT_BITS   = 24;
  localparam int AMOUNT_BITS  = 16;
  localparam int POS_BITS     = 8;
  localparam int OCC_BITS     = 9;
  localparam int STATUS_BITS  = 3;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK     = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_ABSENT = 3'd2,
    STAT_UNDER  = 3'd3,
    STAT_SAT    = 3'd4,
    STAT_BADPOS = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDPOS,
    ST_SCAN,
    ST_DECIDE,
    ST_SHUP,
    ST_INS,
    ST_SHDN,
    ST_PUSH
  } state_t;

endpackage

>>> src/sorted_sparse_histogram.sv
// Sorted key/count table with add, remove, lookup and read-by-position operations.
// One entry memory with a single read and a single write port under a small sequencer.
// Depends on ssh_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | op, key, amount, position
//  out     | output    | out_valid/out_stall| entry_key, entry_count, occupancy, status
//
// A read-entry beat reads the entry at its position before the result; a position out of range
// goes straight to the result. Add, remove and lookup scan the entries up to the key's sorted
// place and then decide; an insert shifts the tail up and writes the new key, an erase shifts
// the tail down. Scan and shift together cover the table about once, as the entry memory has a
// single read port. Reset clears the sequencer state, the entry count and out_valid, not the memory.
// A new beat is taken while the previous result still waits on a stalled output.
module sorted_sparse_histogram #(
  parameter int CAPACITY = ssh_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        op,
  input  logic [ssh_pkg::KEY_BITS-1:0]      key,
  input  logic [ssh_pkg::AMOUNT_BITS-1:0]   amount,
  input  logic [ssh_pkg::POS_BITS-1:0]      position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssh_pkg::KEY_BITS-1:0]      entry_key,
  output logic [ssh_pkg::COUNT_BITS-1:0]    entry_count,
  output logic [ssh_pkg::OCC_BITS-1:0]      occupancy,
  output logic [ssh_pkg::STATUS_BITS-1:0]   status
);

  localparam int KB = ssh_pkg::KEY_BITS;
  localparam int CB = ssh_pkg::COUNT_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ssh_pkg::state_t  st, st_next;
  ssh_pkg::op_t     op_r;
  ssh_pkg::status_t res_status;

  logic [KB-1:0]                  key_r;
  logic [ssh_pkg::AMOUNT_BITS-1:0] amt_r;
  logic [CW-1:0]                  idx, p_r, used;
  logic                           found;
  logic [CB-1:0]                  cnt_r;
  logic [KB-1:0]                  res_key;
  logic [CB-1:0]                  res_count;

  logic [KB+CB-1:0] mem [CAPACITY];
  logic [KB+CB-1:0] rdata;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [KB+CB-1:0] wr_data;

  logic [KB-1:0] rkey;
  logic [CB-1:0] rcnt;
  logic          scan_lt;
  logic [CW-1:0] idx_inc, idx_dec, p_inc, used_dec;
  logic [CW:0]   idx_inc2;
  logic          scan_more, shdn_more, full, under, sat, out_free;
  logic [CB:0]   sum;
  logic [CB-1:0] sum_cnt, new_cnt, diff;

  logic [KB-1:0]                   res_key_o;
  logic [CB-1:0]                   res_count_o;
  logic [ssh_pkg::STATUS_BITS-1:0] res_status_o;

  assign rkey      = rdata[KB+CB-1:CB];
  assign rcnt      = rdata[CB-1:0];
  assign scan_lt   = rkey < key_r;
  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign idx_inc2  = {1'b0, idx} + (CW + 1)'(2);
  assign p_inc     = p_r + CW'(1);
  assign used_dec  = used - CW'(1);
  assign scan_more = scan_lt && (idx_inc < used);
  assign shdn_more = idx_inc2 < {1'b0, used};
  assign full      = used == CW'(CAPACITY);
  assign sum       = {1'b0, cnt_r} + (CB + 1)'(amt_r);
  assign sat       = sum[CB];
  assign sum_cnt   = sat ? '1 : sum[CB-1:0];
  assign new_cnt   = CB'(amt_r);
  assign under     = CB'(amt_r) > cnt_r;
  assign diff      = cnt_r - CB'(amt_r);
  assign out_free  = !out_valid || !out_stall;

  assign entry_key   = res_key_o;
  assign entry_count = res_count_o;
  assign status      = res_status_o;

  always_comb begin
    st_next = st;
    unique case (st)
      ssh_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (ssh_pkg::op_t'(op) == ssh_pkg::OP_READ) begin
            st_next = (32'(position) < 32'(used)) ? ssh_pkg::ST_RDPOS : ssh_pkg::ST_PUSH;
          end else begin
            st_next = (used == '0) ? ssh_pkg::ST_DECIDE : ssh_pkg::ST_SCAN;
          end
        end
      end
      ssh_pkg::ST_RDPOS: st_next = ssh_pkg::ST_PUSH;
      ssh_pkg::ST_SCAN:  st_next = scan_more ? ssh_pkg::ST_SCAN : ssh_pkg::ST_DECIDE;
      ssh_pkg::ST_DECIDE: begin
        st_next = ssh_pkg::ST_PUSH;
        if (op_r == ssh_pkg::OP_ADD) begin
          if (!found && amt_r != '0 && !full) begin
            st_next = (used != p_r) ? ssh_pkg::ST_SHUP : ssh_pkg::ST_INS;
          end
        end else if (op_r == ssh_pkg::OP_REMOVE) begin
          if (found && !under && diff == '0 && p_inc < used) begin
            st_next = ssh_pkg::ST_SHDN;
          end
        end
      end
      ssh_pkg::ST_SHUP: st_next = (idx_dec > p_r) ? ssh_pkg::ST_SHUP : ssh_pkg::ST_INS;
      ssh_pkg::ST_INS:  st_next = ssh_pkg::ST_PUSH;
      ssh_pkg::ST_SHDN: st_next = shdn_more ? ssh_pkg::ST_SHDN : ssh_pkg::ST_PUSH;
      ssh_pkg::ST_PUSH: st_next = out_free ? ssh_pkg::ST_IDLE : ssh_pkg::ST_PUSH;
      default:          st_next = ssh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = st != ssh_pkg::ST_IDLE;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = p_r[AW-1:0];
    wr_data  = rdata;
    unique case (st)
      ssh_pkg::ST_IDLE: begin
        rd_en   = in_valid;
        rd_addr = (ssh_pkg::op_t'(op) == ssh_pkg::OP_READ) ? AW'(position) : '0;
      end
      ssh_pkg::ST_SCAN: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc[AW-1:0];
      end
      ssh_pkg::ST_DECIDE: begin
        rd_en   = 1'b1;
        rd_addr = (op_r == ssh_pkg::OP_ADD) ? used_dec[AW-1:0] : p_inc[AW-1:0];
        if (op_r == ssh_pkg::OP_ADD && found) begin
          wr_en   = 1'b1;
          wr_data = {key_r, sum_cnt};
        end else if (op_r == ssh_pkg::OP_REMOVE && found && !under && diff != '0) begin
          wr_en   = 1'b1;
          wr_data = {key_r, diff};
        end
      end
      ssh_pkg::ST_SHUP: begin
        rd_en   = 1'b1;
        rd_addr = idx_dec[AW-1:0] - AW'(1);
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
      end
      ssh_pkg::ST_INS: begin
        wr_en   = 1'b1;
        wr_data = {key_r, new_cnt};
      end
      ssh_pkg::ST_SHDN: begin
        rd_en   = 1'b1;
        rd_addr = idx_inc2[AW-1:0];
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
      end
      ssh_pkg::ST_RDPOS, ssh_pkg::ST_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ssh_pkg::ST_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ssh_pkg::ST_PUSH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (st == ssh_pkg::ST_INS) begin
        used <= used + CW'(1);
      end else if (st == ssh_pkg::ST_DECIDE && op_r == ssh_pkg::OP_REMOVE && found &&
                   !under && diff == '0 && !(p_inc < used)) begin
        used <= used_dec;
      end else if (st == ssh_pkg::ST_SHDN && !shdn_more) begin
        used <= used_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      ssh_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_r       <= ssh_pkg::op_t'(op);
          key_r      <= key;
          amt_r      <= amount;
          idx        <= '0;
          p_r        <= '0;
          found      <= 1'b0;
          res_key    <= '0;
          res_count  <= '0;
          res_status <= ssh_pkg::STAT_BADPOS;
        end
      end
      ssh_pkg::ST_RDPOS: begin
        res_key    <= rkey;
        res_count  <= rcnt;
        res_status <= ssh_pkg::STAT_OK;
      end
      ssh_pkg::ST_SCAN: begin
        if (scan_more) begin
          idx <= idx_inc;
        end else if (scan_lt) begin
          p_r   <= used;
          found <= 1'b0;
        end else begin
          p_r   <= idx;
          found <= rkey == key_r;
          cnt_r <= rcnt;
        end
      end
      ssh_pkg::ST_DECIDE: begin
        res_key <= key_r;
        unique case (op_r)
          ssh_pkg::OP_ADD: begin
            if (found) begin
              res_count  <= sum_cnt;
              res_status <= sat ? ssh_pkg::STAT_SAT : ssh_pkg::STAT_OK;
            end else if (amt_r == '0) begin
              res_count  <= '0;
              res_status <= ssh_pkg::STAT_OK;
            end else if (full) begin
              res_count  <= '0;
              res_status <= ssh_pkg::STAT_FULL;
            end else begin
              res_count  <= new_cnt;
              res_status <= ssh_pkg::STAT_OK;
              idx        <= used;
            end
          end
          ssh_pkg::OP_REMOVE: begin
            if (!found) begin
              res_count  <= '0;
              res_status <= ssh_pkg::STAT_ABSENT;
            end else if (under) begin
              res_count  <= cnt_r;
              res_status <= ssh_pkg::STAT_UNDER;
            end else begin
              res_count  <= diff;
              res_status <= ssh_pkg::STAT_OK;
              idx        <= p_r;
            end
          end
          ssh_pkg::OP_LOOKUP: begin
            res_count  <= found ? cnt_r : '0;
            res_status <= ssh_pkg::STAT_OK;
          end
          ssh_pkg::OP_READ: begin
          end
          default: begin
          end
        endcase
      end
      ssh_pkg::ST_SHUP: idx <= idx_dec;
      ssh_pkg::ST_SHDN: idx <= idx_inc;
      ssh_pkg::ST_PUSH: begin
        if (out_free) begin
          res_key_o    <= res_key;
          res_count_o  <= res_count;
          res_status_o <= res_status;
          occupancy    <= ssh_pkg::OCC_BITS'(used);
        end
      end
      ssh_pkg::ST_INS: begin
      end
      default: begin
      end
    endcase
  end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for sorted_sparse_histogram: directed and random beats on the
// input channel, with every result compared against a behavioral model of the sorted table.
// Depends on ssh_pkg and the sorted_sparse_histogram RTL.
module testbench;

  localparam int CAP = ssh_pkg::CAPACITY_DEF;
  localparam int KB  = ssh_pkg::KEY_BITS;
  localparam int CB  = ssh_pkg::COUNT_BITS;
  localparam int AB  = ssh_pkg::AMOUNT_BITS;
  localparam int PB  = ssh_pkg::POS_BITS;
  localparam int OB  = ssh_pkg::OCC_BITS;
  localparam int SB  = ssh_pkg::STATUS_BITS;
  localparam logic [CB-1:0] COUNT_TOP = '1;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [KB-1:0] entry_key;
    logic [CB-1:0] entry_count;
    logic [OB-1:0] occupancy;
    logic [SB-1:0] status;
  } result_t;

  class histogram_tracker;
    logic [KB-1:0] slot_key [CAP];
    logic [CB-1:0] slot_cnt [CAP];
    int unsigned   n_used;
    result_t       expected [$];
    int unsigned   errors;

    function new();
      n_used = 0;
      errors = 0;
    endfunction

    function int unsigned find_slot(logic [KB-1:0] k);
      int unsigned at;
      at = 0;
      while (at < n_used && slot_key[at] < k) at++;
      return at;
    endfunction

    function logic [CB-1:0] count_of(logic [KB-1:0] k);
      int unsigned at;
      at = find_slot(k);
      if (at < n_used && slot_key[at] == k) return slot_cnt[at];
      return '0;
    endfunction

    function void note_beat(ssh_pkg::op_t code, logic [KB-1:0] k,
                            logic [AB-1:0] amt, logic [PB-1:0] pos);
      result_t     r;
      int unsigned at;
      int unsigned i;
      bit          hit;
      logic [CB:0] sum;
      r.entry_key   = k;
      r.entry_count = '0;
      r.status      = ssh_pkg::STAT_OK;
      if (code == ssh_pkg::OP_READ) begin
        if (32'(pos) < n_used) begin
          r.entry_key   = slot_key[pos];
          r.entry_count = slot_cnt[pos];
        end else begin
          r.entry_key = '0;
          r.status    = ssh_pkg::STAT_BADPOS;
        end
      end else begin
        at  = find_slot(k);
        hit = at < n_used && slot_key[at] == k;
        case (code)
          ssh_pkg::OP_ADD: begin
            if (hit) begin
              sum = {1'b0, slot_cnt[at]} + (CB + 1)'(amt);
              if (sum > {1'b0, COUNT_TOP}) begin
                sum      = {1'b0, COUNT_TOP};
                r.status = ssh_pkg::STAT_SAT;
              end
              slot_cnt[at]  = sum[CB-1:0];
              r.entry_count = sum[CB-1:0];
            end else if (amt == '0) begin
              r.entry_count = '0;
            end else if (n_used >= CAP) begin
              r.status = ssh_pkg::STAT_FULL;
            end else begin
              for (i = n_used; i > at; i--) begin
                slot_key[i] = slot_key[i-1];
                slot_cnt[i] = slot_cnt[i-1];
              end
              slot_key[at]  = k;
              slot_cnt[at]  = CB'(amt);
              r.entry_count = CB'(amt);
              n_used++;
            end
          end
          ssh_pkg::OP_REMOVE: begin
            if (!hit) begin
              r.status = ssh_pkg::STAT_ABSENT;
            end else if (CB'(amt) > slot_cnt[at]) begin
              r.status      = ssh_pkg::STAT_UNDER;
              r.entry_count = slot_cnt[at];
            end else begin
              slot_cnt[at]  = slot_cnt[at] - CB'(amt);
              r.entry_count = slot_cnt[at];
              if (slot_cnt[at] == '0) begin
                for (i = at; i + 1 < n_used; i++) begin
                  slot_key[i] = slot_key[i+1];
                  slot_cnt[i] = slot_cnt[i+1];
                end
                n_used--;
              end
            end
          end
          default: begin
            if (hit) r.entry_count = slot_cnt[at];
          end
        endcase
      end
      r.occupancy = OB'(n_used);
      expected.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        $error("result beat with no expectation pending: entry_key %0h", got.entry_key);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.entry_key !== want.entry_key) begin
        $error("entry_key: expected %0h, actual %0h", want.entry_key, got.entry_key);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0h, actual %0h", want.entry_count, got.entry_count);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    op = '0;
  logic [KB-1:0] key = '0;
  logic [AB-1:0] amount = '0;
  logic [PB-1:0] position = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [KB-1:0] entry_key;
  logic [CB-1:0] entry_count;
  logic [OB-1:0] occupancy;
  logic [SB-1:0] status;

  histogram_tracker tracker;
  logic [KB-1:0]    key_pool [32];
  int unsigned      gap_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      cycle_count = 0;

  sorted_sparse_histogram i_dut (
    .clk, .rst, .in_valid, .in_stall, .op, .key, .amount, .position,
    .out_valid, .out_stall, .entry_key, .entry_count, .occupancy, .status
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_result('{entry_key, entry_count, occupancy, status});
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(ssh_pkg::op_t code, logic [KB-1:0] k, logic [AB-1:0] amt,
                           logic [PB-1:0] pos);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    key      <= k;
    amount   <= amt;
    position <= pos;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_beat(code, k, amt, pos);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.expected.size() != 0);
  endtask

  task automatic run_mixed(int unsigned beats, bit quiet);
    logic [KB-1:0] k;
    logic [CB-1:0] cnt;
    logic [AB-1:0] amt;
    logic [PB-1:0] pos;
    int unsigned   roll;
    int unsigned   n;
    ssh_pkg::op_t  code;
    for (n = 0; n < beats; n++) begin
      if (n % 100 == 0) begin
        if (quiet) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          case ($urandom_range(0, 2))
            0: begin
              gap_pct   = 0;
              stall_pct = 0;
            end
            1: begin
              gap_pct   = 15;
              stall_pct = 4;
            end
            default: begin
              gap_pct   = 40;
              stall_pct = 10;
            end
          endcase
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) k = key_pool[$urandom_range(0, 31)];
      else if (roll < 85 && tracker.n_used != 0)
        k = tracker.slot_key[$urandom_range(0, tracker.n_used - 1)];
      else k = KB'($urandom);
      if (tracker.n_used != 0 && $urandom_range(0, 9) < 7)
        pos = PB'($urandom_range(0, tracker.n_used));
      else pos = PB'($urandom);
      roll = $urandom_range(0, 99);
      code = roll < 40 ? ssh_pkg::OP_ADD : roll < 70 ? ssh_pkg::OP_REMOVE :
             roll < 85 ? ssh_pkg::OP_LOOKUP : ssh_pkg::OP_READ;
      roll = $urandom_range(0, 99);
      if (code == ssh_pkg::OP_REMOVE && roll < 40) begin
        cnt = tracker.count_of(k);
        amt = cnt[CB-1:AB] != '0 ? '1 : cnt[AB-1:0];
      end else if (roll < 65) amt = AB'($urandom_range(1, 16));
      else if (roll < 78) amt = '0;
      else amt = AB'($urandom);
      send_beat(code, k, amt, pos);
    end
  endtask

  initial begin
    logic [KB-1:0] k;
    logic [AB-1:0] amt;
    int unsigned   p;
    int unsigned   i;
    tracker = new();
    for (i = 0; i < 32; i++) key_pool[i] = KB'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 20;
    stall_pct = 5;
    send_beat(ssh_pkg::OP_LOOKUP, 16'h0000, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_READ,   16'h0000, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_REMOVE, 16'h1234, 16'h0001, 8'h00);
    send_beat(ssh_pkg::OP_ADD,    16'h0042, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_ADD,    16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(ssh_pkg::OP_ADD,    16'h0000, 16'h0001, 8'h00);
    send_beat(ssh_pkg::OP_ADD,    16'h8000, 16'h0001, 8'h80);
    send_beat(ssh_pkg::OP_ADD,    16'hFFFF, 16'hFFFF, 8'h00);
    send_beat(ssh_pkg::OP_READ,   16'h0000, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_READ,   16'h0000, 16'h0000, 8'h01);
    send_beat(ssh_pkg::OP_READ,   16'h0000, 16'h0000, 8'h02);
    send_beat(ssh_pkg::OP_READ,   16'h0000, 16'h0000, 8'h03);
    send_beat(ssh_pkg::OP_READ,   16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(ssh_pkg::OP_LOOKUP, 16'h8000, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_LOOKUP, 16'h7FFF, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_REMOVE, 16'h8000, 16'h0002, 8'h00);
    send_beat(ssh_pkg::OP_REMOVE, 16'h8000, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_REMOVE, 16'h8000, 16'h0001, 8'h00);
    send_beat(ssh_pkg::OP_REMOVE, 16'h0000, 16'hFFFF, 8'h00);
    send_beat(ssh_pkg::OP_ADD,    16'h0000, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_REMOVE, 16'hFFFF, 16'hFFFF, 8'h00);
    send_beat(ssh_pkg::OP_ADD,    16'h5555, 16'hAAAA, 8'h55);
    send_beat(ssh_pkg::OP_ADD,    16'hAAAA, 16'h5555, 8'hAA);
    send_beat(ssh_pkg::OP_READ,   16'h0000, 16'h0000, 8'h01);
    send_beat(ssh_pkg::OP_READ,   16'h0000, 16'h0000, 8'h02);

    gap_pct   = 10;
    stall_pct = 3;
    while (tracker.n_used < CAP) begin
      send_beat(ssh_pkg::OP_ADD, KB'($urandom), AB'($urandom_range(1, 65535)),
                PB'($urandom));
    end
    do k = KB'($urandom); while (tracker.count_of(k) != '0);
    send_beat(ssh_pkg::OP_ADD, k, 16'h0001, 8'h00);
    send_beat(ssh_pkg::OP_ADD, k, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_READ, 16'h0000, 16'h0000, 8'hFF);
    send_beat(ssh_pkg::OP_ADD, tracker.slot_key[CAP-1], 16'h0003, 8'h00);
    for (i = 0; i < 24; i++) begin
      send_beat(i[0] ? ssh_pkg::OP_READ : ssh_pkg::OP_LOOKUP,
                tracker.slot_key[$urandom_range(0, CAP - 1)], 16'h0000, PB'($urandom));
    end
    wait_drained();

    gap_pct   = 25;
    stall_pct = 8;
    k = tracker.slot_key[0];
    while (tracker.count_of(k) != COUNT_TOP) send_beat(ssh_pkg::OP_ADD, k, '1, 8'h00);
    send_beat(ssh_pkg::OP_ADD, k, 16'h0001, 8'h00);
    send_beat(ssh_pkg::OP_ADD, k, 16'h0000, 8'h00);
    send_beat(ssh_pkg::OP_REMOVE, k, '1, 8'h00);
    send_beat(ssh_pkg::OP_LOOKUP, k, 16'h0000, 8'h00);
    wait_drained();

    for (i = 0; i < 400 && tracker.n_used > 24; i++) begin
      p = $urandom_range(0, tracker.n_used - 1);
      k = tracker.slot_key[p];
      if (tracker.slot_cnt[p][CB-1:AB] != '0) amt = '1;
      else if ($urandom_range(0, 3) == 0) amt = AB'($urandom);
      else amt = tracker.slot_cnt[p][AB-1:0];
      send_beat(ssh_pkg::OP_REMOVE, k, amt, PB'($urandom));
    end

    run_mixed(300, 1'b0);
    run_mixed(150, 1'b1);

    wait_drained();
    repeat (2 * CAP + 16) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/ssh_pkg.sv
src/sorted_sparse_histogram.sv
verif/testbench.sv
